// ===== hw/rtl/hptt_pkg.sv =====
package hptt_pkg;

    localparam int VIRT_W = 47;
    localparam int PHYS_W = 52;
    localparam int ROOT_W = 64;
    localparam int MODE_W = 3;
    localparam int STATUS_W = 3;
    localparam int PAGES_W = 10;
    localparam int COUNT_W = 7;
    localparam int TOTAL_W = 32;

    localparam int IN_TDATA_W = 168;
    localparam int OUT_TDATA_W = 96;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_TRACK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNTRACK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPLIT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COLLAPSE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEFER = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd4;

    localparam logic [PAGES_W-1:0] SMALL_PAGES = 10'd512;

    // One table record as it is kept in the entry memory.
    typedef struct packed {
        logic              present;
        logic              is_split;
        logic [ROOT_W-1:0] root;
        logic [PHYS_W-1:0] phys;
        logic [VIRT_W-1:0] virt;
    } entry_t;

    typedef struct packed {
        logic [1:0]        pad;
        logic [ROOT_W-1:0] root_tag;
        logic [PHYS_W-1:0] phys_address;
        logic [VIRT_W-1:0] virt_address;
        logic [MODE_W-1:0] mode;
    } in_word_t;

    typedef struct packed {
        logic [4:0]          pad;
        logic [COUNT_W-1:0]  queued_count;
        logic [TOTAL_W-1:0]  split_total;
        logic [TOTAL_W-1:0]  merged_total;
        logic [COUNT_W-1:0]  tracked_total;
        logic [PAGES_W-1:0]  pages_split;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TSCAN = 6'b000010,
        S_TMOD  = 6'b000100,
        S_QSCAN = 6'b001000,
        S_DONE  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

endpackage

// ===== hw/rtl/hptt_ram.sv =====
module hptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    wen,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    ren,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Simple dual-port memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/huge_page_tracking_table.sv =====
// Huge-page tracking table. Each input word carries one management operation (track,
// untrack, split, collapse or deferred split) and yields exactly one result word with the
// status, the split page count and the current totals. Records live in an entry memory
// and deferred addresses in a queue memory, both with a registered read. An
// operation that needs a lookup walks the used part of the table (or of the queue) one
// entry per clock, up to the last table entry in use (or the last queue slot in use for a
// deferred split). Operations that are decided early (disabled but for untrack,
// misaligned, full table on track, unused modes) skip the lookup. One operation is in
// work at a time; a finished result sits in an output register, so the block takes
// the next word while the previous result still waits on the master side. The
// tracking enable is written through cfg_wen and cfg_wdata and must only change while
// the block is idle.
module huge_page_tracking_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int QUEUE_DEPTH = 64,
    parameter int HUGE_PAGE_SHIFT = 21
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic                             cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: mode[3], virt_address[47], phys_address[52], root_tag[64], zeros.
    input  logic [hptt_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: status[3], pages_split[10], tracked_total[7], merged_total[32],
    // split_total[32], queued_count[7], zeros.
    output logic [hptt_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import hptt_pkg::*;

    localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TCW = $clog2(TABLE_DEPTH + 1);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = $bits(entry_t);

    // Control state.
    state_t             state_reg, state_next;
    logic               enabled_reg;
    logic [TCW-1:0]     used_reg, used_next;
    logic [TCW-1:0]     present_reg, present_next;
    logic [QCW-1:0]     qused_reg, qused_next;
    logic [TOTAL_W-1:0] merge_reg, merge_next;
    logic [TOTAL_W-1:0] split_reg, split_next;
    logic [TCW-1:0]     tidx_reg, tidx_next;
    logic [QCW-1:0]     qidx_reg, qidx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               out_vld_reg, out_vld_next;

    // Payload registers.
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [VIRT_W-1:0]   va_reg, va_next;
    logic [PHYS_W-1:0]   pa_reg, pa_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PAGES_W-1:0]  pages_reg, pages_next;
    logic [TAW-1:0]      chk_reg, chk_next;
    logic [TAW-1:0]      hit_reg, hit_next;
    entry_t              word_reg, word_next;
    out_word_t           out_reg, out_next;

    // Memory ports.
    logic               tbl_wen, tbl_ren;
    logic [TAW-1:0]     tbl_waddr, tbl_raddr;
    entry_t             tbl_wdata;
    logic [ENTRY_W-1:0] tbl_rdata;
    entry_t             tbl_entry;
    logic               q_wen, q_ren;
    logic [QAW-1:0]     q_waddr, q_raddr;
    logic [VIRT_W-1:0]  q_rdata;

    in_word_t in_word;
    logic     in_accept;
    logic     in_aligned;
    logic     tbl_hit;
    logic     q_hit;

    hptt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .clk  (clk),
        .wen  (tbl_wen),
        .waddr(tbl_waddr),
        .wdata(tbl_wdata),
        .ren  (tbl_ren),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    hptt_ram #(
        .WIDTH(VIRT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue_ram (
        .clk  (clk),
        .wen  (q_wen),
        .waddr(q_waddr),
        .wdata(va_reg),
        .ren  (q_ren),
        .raddr(q_raddr),
        .rdata(q_rdata)
    );

    assign in_word = in_word_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_aligned = (in_word.virt_address[HUGE_PAGE_SHIFT-1:0] == '0);
    assign tbl_entry = entry_t'(tbl_rdata);

    // A lookup matches only a present record with the same virtual address.
    assign tbl_hit = rd_vld_reg && tbl_entry.present && (tbl_entry.virt == va_reg);
    assign q_hit = rd_vld_reg && (q_rdata == va_reg);

    assign m_tvalid = out_vld_reg;
    assign m_tdata = out_reg;

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        present_next = present_reg;
        qused_next = qused_reg;
        merge_next = merge_reg;
        split_next = split_reg;
        tidx_next = tidx_reg;
        qidx_next = qidx_reg;
        rd_vld_next = 1'b0;
        out_vld_next = out_vld_reg && !m_tready;
        mode_next = mode_reg;
        va_next = va_reg;
        pa_next = pa_reg;
        root_next = root_reg;
        status_next = status_reg;
        pages_next = pages_reg;
        chk_next = chk_reg;
        hit_next = hit_reg;
        word_next = word_reg;
        out_next = out_reg;

        tbl_wen = 1'b0;
        tbl_ren = 1'b0;
        tbl_waddr = used_reg[TAW-1:0];
        tbl_raddr = tidx_reg[TAW-1:0];
        tbl_wdata = word_reg;
        q_wen = 1'b0;
        q_ren = 1'b0;
        q_waddr = qused_reg[QAW-1:0];
        q_raddr = qidx_reg[QAW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next = in_word.mode;
                    va_next = in_word.virt_address;
                    pa_next = in_word.phys_address;
                    root_next = in_word.root_tag;
                    status_next = ST_OK;
                    pages_next = '0;
                    tidx_next = '0;
                    qidx_next = '0;
                    state_next = S_DONE;
                    // Early decisions; anything that needs a lookup starts a scan.
                    if (in_word.mode == MODE_UNTRACK)
                    begin
                        state_next = S_TSCAN;
                    end
                    else if (in_word.mode > MODE_DEFER)
                    begin
                        status_next = ST_OK;
                    end
                    else if (!enabled_reg)
                    begin
                        status_next = ST_DISABLED;
                    end
                    else if (in_word.mode == MODE_TRACK)
                    begin
                        if (used_reg >= TCW'(TABLE_DEPTH))
                        begin
                            status_next = ST_NO_SPACE;
                        end
                        else
                        begin
                            state_next = S_TSCAN;
                        end
                    end
                    else if (!in_aligned)
                    begin
                        status_next = ST_MISALIGNED;
                    end
                    else if (in_word.mode == MODE_DEFER && qused_reg < QCW'(QUEUE_DEPTH))
                    begin
                        state_next = S_QSCAN;
                    end
                    else
                    begin
                        // Split, collapse, or a deferred split with a full queue.
                        state_next = S_TSCAN;
                    end
                end
            end

            S_TSCAN:
            begin
                if (tbl_hit)
                begin
                    hit_next = chk_reg;
                    word_next = tbl_entry;
                    state_next = S_TMOD;
                end
                else if (tidx_reg < used_reg)
                begin
                    tbl_ren = 1'b1;
                    rd_vld_next = 1'b1;
                    chk_next = tidx_reg[TAW-1:0];
                    tidx_next = tidx_reg + 1'b1;
                end
                else
                begin
                    // The whole used part of the table was searched without a match.
                    state_next = S_DONE;
                    tbl_wdata.virt = va_reg;
                    tbl_wdata.phys = pa_reg;
                    tbl_wdata.root = (mode_reg == MODE_TRACK) ? root_reg : '0;
                    tbl_wdata.is_split = 1'b0;
                    tbl_wdata.present = 1'b1;
                    case (mode_reg)
                        MODE_TRACK:
                        begin
                            tbl_wen = 1'b1;
                            used_next = used_reg + 1'b1;
                            present_next = present_reg + 1'b1;
                        end
                        MODE_COLLAPSE:
                        begin
                            if (used_reg >= TCW'(TABLE_DEPTH))
                            begin
                                status_next = ST_NO_SPACE;
                            end
                            else
                            begin
                                tbl_wen = 1'b1;
                                used_next = used_reg + 1'b1;
                                present_next = present_reg + 1'b1;
                                merge_next = merge_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_TMOD:
            begin
                // Write the matched record back with its flags updated.
                tbl_wen = 1'b1;
                tbl_waddr = hit_reg;
                state_next = S_DONE;
                case (mode_reg)
                    MODE_UNTRACK:
                    begin
                        tbl_wdata.present = 1'b0;
                        present_next = present_reg - 1'b1;
                    end
                    MODE_COLLAPSE:
                    begin
                        if (word_reg.is_split)
                        begin
                            tbl_wdata.is_split = 1'b0;
                            merge_next = merge_reg + 1'b1;
                        end
                    end
                    MODE_SPLIT, MODE_DEFER:
                    begin
                        if (!word_reg.is_split)
                        begin
                            tbl_wdata.is_split = 1'b1;
                            split_next = split_reg + 1'b1;
                            pages_next = SMALL_PAGES;
                        end
                    end
                    default:
                    begin
                        // A track of an address that is already present changes nothing.
                    end
                endcase
            end

            S_QSCAN:
            begin
                if (q_hit)
                begin
                    state_next = S_DONE;
                end
                else if (qidx_reg < qused_reg)
                begin
                    q_ren = 1'b1;
                    rd_vld_next = 1'b1;
                    qidx_next = qidx_reg + 1'b1;
                end
                else
                begin
                    q_wen = 1'b1;
                    qused_next = qused_reg + 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_next.pad = '0;
                    out_next.status = status_reg;
                    out_next.pages_split = pages_reg;
                    out_next.tracked_total = COUNT_W'(present_reg);
                    out_next.merged_total = merge_reg;
                    out_next.split_total = split_reg;
                    out_next.queued_count = COUNT_W'(qused_reg);
                    out_vld_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            enabled_reg <= 1'b1;
            used_reg <= '0;
            present_reg <= '0;
            qused_reg <= '0;
            merge_reg <= '0;
            split_reg <= '0;
            tidx_reg <= '0;
            qidx_reg <= '0;
            rd_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                enabled_reg <= cfg_wdata;
            end
            used_reg <= used_next;
            present_reg <= present_next;
            qused_reg <= qused_next;
            merge_reg <= merge_next;
            split_reg <= split_next;
            tidx_reg <= tidx_next;
            qidx_reg <= qidx_next;
            rd_vld_reg <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        va_reg <= va_next;
        pa_reg <= pa_next;
        root_reg <= root_next;
        status_reg <= status_next;
        pages_reg <= pages_next;
        chk_reg <= chk_next;
        hit_reg <= hit_next;
        word_reg <= word_next;
        out_reg <= out_next;
    end

`ifndef SYNTH
    // The present count never exceeds the number of used table entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        present_reg <= used_reg)
    else $error("present count exceeds used table entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= TCW'(TABLE_DEPTH) && qused_reg <= QCW'(QUEUE_DEPTH))
    else $error("table or queue fill count out of range");

    // Every accepted word starts work, so the input side closes after it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != S_IDLE)
    else $error("accepted word did not start an operation");

    // The entry memory is written only while a lookup finishes or a record is updated.
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wen |-> (state_reg == S_TSCAN || state_reg == S_TMOD))
    else $error("entry memory written outside a lookup");
`endif

endmodule
